### rtl/lp2ab_pkg.sv
package lp2ab_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  out_byte;
        logic [1:0]  status_code;
        logic [31:0] unit_count;
        logic        run_last;
    } out_item_t;

    typedef enum logic [1:0] {
        LEN_1BYTE   = 2'd0,
        LEN_2BYTE   = 2'd1,
        LEN_4BYTE   = 2'd2,
        LEN_INVALID = 2'd3
    } len_code_t;

    typedef enum logic [1:0] {
        SC_NONE  = 2'd0,
        SC_SHORT = 2'd1,
        SC_LONG  = 2'd2
    } sc_kind_t;

    typedef struct packed {
        sc_kind_t    sc;
        logic        data_en;
        logic [7:0]  data;
        logic        stat_en;
        logic [1:0]  status;
        logic [31:0] count;
    } job_t;

    localparam len_code_t LEN_CODE_RESET = LEN_4BYTE;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE    = 2'd1;
    localparam logic [1:0] ST_PAYLOAD_CUT = 2'd2;
    localparam logic [1:0] ST_LENGTH_CUT  = 2'd3;

    localparam logic [2:0] SC_LONG_LEN  = 3'd4;
    localparam logic [2:0] SC_SHORT_LEN = 3'd3;
    localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
    localparam logic [7:0] SC_TAIL_BYTE = 8'h01;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

### rtl/lp2ab_front.sv
module lp2ab_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  lp2ab_pkg::len_code_t len_code,
    input  logic                s_valid,
    output logic                s_ready,
    input  lp2ab_pkg::in_item_t s_data,
    input  logic                q_full,
    output logic                q_push,
    output lp2ab_pkg::job_t     q_job
);
    import lp2ab_pkg::*;

    logic        in_payload_reg, in_payload_next;
    logic [1:0]  seen_reg, seen_next;
    logic [31:0] accum_reg, accum_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] units_reg, units_next;

    logic        accept;
    logic [2:0]  need;
    logic [2:0]  seen_inc;
    logic [31:0] accum_shift;
    logic [31:0] left_dec;
    job_t        job;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    always_comb begin
        unique case (len_code)
            LEN_1BYTE:   need = 3'd1;
            LEN_2BYTE:   need = 3'd2;
            LEN_4BYTE:   need = 3'd4;
            LEN_INVALID: need = 3'd4;
            default:     need = 3'd4;
        endcase
    end

    assign seen_inc    = {1'b0, seen_reg} + 3'd1;
    assign accum_shift = {accum_reg[23:0], s_data.in_byte};
    assign left_dec    = left_reg - 32'd1;

    always_comb begin
        in_payload_next = in_payload_reg;
        seen_next       = seen_reg;
        accum_next      = accum_reg;
        left_next       = left_reg;
        units_next      = units_reg;
        job             = '0;
        job.sc          = SC_NONE;

        if (len_code != LEN_INVALID) begin
            if (in_payload_reg) begin
                job.data_en = 1'b1;
                job.data    = s_data.in_byte;
                left_next   = left_dec;
                if (left_dec == 32'd0) begin
                    in_payload_next = 1'b0;
                end
            end else begin
                accum_next = accum_shift;
                seen_next  = seen_inc[1:0];
                if (seen_inc >= need) begin
                    job.sc          = (units_reg == 32'd0) ? SC_LONG : SC_SHORT;
                    units_next      = (units_reg == COUNT_MAX) ? units_reg
                                                               : units_reg + 32'd1;
                    left_next       = accum_shift;
                    in_payload_next = (accum_shift != 32'd0);
                    accum_next      = 32'd0;
                    seen_next       = 2'd0;
                end
            end
        end

        if (s_data.in_last) begin
            job.stat_en = 1'b1;
            job.count   = units_next;
            priority if (len_code == LEN_INVALID) begin
                job.status = ST_BAD_SIZE;
            end else if (in_payload_next && (left_next != 32'd0)) begin
                job.status = ST_PAYLOAD_CUT;
            end else if (seen_next != 2'd0) begin
                job.status = ST_LENGTH_CUT;
            end else begin
                job.status = ST_OK;
            end
            in_payload_next = 1'b0;
            seen_next       = 2'd0;
            accum_next      = 32'd0;
            left_next       = 32'd0;
            units_next      = 32'd0;
        end
    end

    assign q_job  = job;
    assign q_push = accept && ((job.sc != SC_NONE) || job.data_en || job.stat_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            seen_reg       <= 2'd0;
            accum_reg      <= 32'd0;
            left_reg       <= 32'd0;
            units_reg      <= 32'd0;
        end else if (accept) begin
            in_payload_reg <= in_payload_next;
            seen_reg       <= seen_next;
            accum_reg      <= accum_next;
            left_reg       <= left_next;
            units_reg      <= units_next;
        end
    end

endmodule

### rtl/lp2ab_queue.sv
module lp2ab_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lp2ab_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output lp2ab_pkg::job_t head_job
);
    import lp2ab_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/lp2ab_back.sv
module lp2ab_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  lp2ab_pkg::job_t      head_job,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lp2ab_pkg::out_item_t m_data
);
    import lp2ab_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg;
    out_item_t  item;
    logic [2:0] n_sc;
    logic [2:0] total;
    logic       last_item;
    logic       fire;

    always_comb begin
        unique case (head_job.sc)
            SC_NONE:  n_sc = 3'd0;
            SC_SHORT: n_sc = SC_SHORT_LEN;
            SC_LONG:  n_sc = SC_LONG_LEN;
            default:  n_sc = 3'd0;
        endcase
    end

    assign total     = n_sc + {2'b0, head_job.data_en} + {2'b0, head_job.stat_en};
    assign last_item = (idx_reg == total - 3'd1);
    assign fire      = !q_empty && (!m_valid_reg || m_ready);
    assign q_pop     = fire && last_item;

    always_comb begin
        item          = '0;
        item.run_last = last_item;
        priority if (idx_reg < n_sc) begin
            item.item_kind = KIND_DATA;
            item.out_byte  = (idx_reg == n_sc - 3'd1) ? SC_TAIL_BYTE : SC_ZERO_BYTE;
        end else if ((idx_reg == n_sc) && head_job.data_en) begin
            item.item_kind = KIND_DATA;
            item.out_byte  = head_job.data;
        end else begin
            item.item_kind   = KIND_STATUS;
            item.status_code = head_job.status;
            item.unit_count  = head_job.count;
        end
    end

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (fire) begin
            idx_next     = last_item ? 3'd0 : idx_reg + 3'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/length_prefixed_to_annexb_unit.sv
// Each result beat is held in the job queue and then in the output register.
// Throughput: while m_ready is high, one result beat and one payload byte per cycle.
// A completed length field expands into three or four start code beats, and the
// job queue between the front and back parts absorbs that before input stalls.
// Synchronous active-low reset clears the unit state, the queue and the output,
// and sets the length field size to four bytes.
module length_prefixed_to_annexb_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lp2ab_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lp2ab_pkg::out_item_t m_data
);
    import lp2ab_pkg::*;

    len_code_t len_code_reg;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    job_t      push_job;
    job_t      head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_code_reg <= LEN_CODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            len_code_reg <= len_code_t'(cfg_data);
        end
    end

    lp2ab_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .len_code (len_code_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    lp2ab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    lp2ab_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head_job (head_job),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A status beat always closes the run of beats caused by its input byte.
    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.item_kind == KIND_STATUS)) |-> m_data.run_last)
        else $error("status beat without run_last");

    a_data_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.item_kind == KIND_DATA))
            |-> ((m_data.status_code == ST_OK) && (m_data.unit_count == 32'd0)))
        else $error("data beat carries status fields");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> (!q_push && !s_ready))
        else $error("job pushed into a full queue");

    a_pop_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid)
        else $error("job retired without a result beat");

endmodule

### sim/length_prefixed_to_annexb_unit_test.sv
`timescale 1ns / 1ps

module length_prefixed_to_annexb_unit_test;

    import lp2ab_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    class annexb_scoreboard;
        len_code_t   len_code;
        logic        in_payload;
        logic [1:0]  len_seen;
        logic [31:0] len_accum;
        logic [31:0] payload_left;
        logic [31:0] units;
        out_item_t   expected_q[$];
        int          errors;

        function new();
            len_code = LEN_CODE_RESET;
            errors   = 0;
            clear_unit();
        endfunction

        function void clear_unit();
            in_payload   = 1'b0;
            len_seen     = 2'd0;
            len_accum    = '0;
            payload_left = '0;
            units        = '0;
        endfunction

        function void set_len_code(len_code_t code);
            len_code = code;
        endfunction

        function void push_beat(logic kind, logic [7:0] data, logic [1:0] status,
                                logic [31:0] count);
            out_item_t beat;
            beat.item_kind   = kind;
            beat.out_byte    = data;
            beat.status_code = status;
            beat.unit_count  = count;
            beat.run_last    = 1'b0;
            expected_q = {expected_q, beat};
        endfunction

        function void note_input(in_item_t beat);
            int         first_new;
            int         need;
            int         seen_now;
            logic [1:0] status;
            first_new = expected_q.size();
            need = (len_code == LEN_1BYTE) ? 1 : (len_code == LEN_2BYTE) ? 2 : 4;
            if (len_code != LEN_INVALID) begin
                if (in_payload) begin
                    push_beat(KIND_DATA, beat.in_byte, ST_OK, '0);
                    payload_left = payload_left - 1;
                    if (payload_left == 0) begin
                        in_payload = 1'b0;
                    end
                end else begin
                    len_accum = {len_accum[23:0], beat.in_byte};
                    seen_now  = len_seen + 1;
                    if (seen_now >= need) begin
                        if (units == 0) begin
                            push_beat(KIND_DATA, SC_ZERO_BYTE, ST_OK, '0);
                        end
                        push_beat(KIND_DATA, SC_ZERO_BYTE, ST_OK, '0);
                        push_beat(KIND_DATA, SC_ZERO_BYTE, ST_OK, '0);
                        push_beat(KIND_DATA, SC_TAIL_BYTE, ST_OK, '0);
                        if (units != COUNT_MAX) begin
                            units = units + 1;
                        end
                        payload_left = len_accum;
                        in_payload   = (len_accum != 0);
                        len_accum    = '0;
                        len_seen     = 2'd0;
                    end else begin
                        len_seen = seen_now[1:0];
                    end
                end
            end
            if (beat.in_last) begin
                if (len_code == LEN_INVALID) begin
                    status = ST_BAD_SIZE;
                end else if (in_payload && payload_left != 0) begin
                    status = ST_PAYLOAD_CUT;
                end else if (len_seen != 0) begin
                    status = ST_LENGTH_CUT;
                end else begin
                    status = ST_OK;
                end
                push_beat(KIND_STATUS, 8'h00, status, units);
                clear_unit();
            end
            if (expected_q.size() > first_new) begin
                expected_q[expected_q.size() - 1].run_last = 1'b1;
            end
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                compare_field("item_kind", want.item_kind, got.item_kind);
                compare_field("out_byte", want.out_byte, got.out_byte);
                compare_field("status_code", want.status_code, got.status_code);
                compare_field("unit_count", want.unit_count, got.unit_count);
                compare_field("run_last", want.run_last, got.run_last);
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    annexb_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int counted_beats = 0;
    int idle_cycles = 0;

    length_prefixed_to_annexb_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL length_prefixed_to_annexb_unit");
                $finish;
            end
        end
    end

    // All driving tasks start and end at a falling edge.
    task automatic send_beat(logic [7:0] data, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_data.in_byte = data;
        s_data.in_last = last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (sb.len_code != LEN_INVALID || last) begin
            counted_beats++;
        end
        sb.note_input(s_data);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_len_code(len_code_t code);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = code;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        sb.set_len_code(code);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_buffer(logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++) begin
            send_beat(bytes[i], i == bytes.size() - 1);
        end
    endtask

    // Mostly well-formed buffers; some are cut short at a random byte and some
    // are plain noise.
    task automatic send_random_buffer();
        logic [7:0]  bytes[$];
        logic [31:0] field;
        int          need;
        int          roll;
        int          units;
        int          body;
        int          keep;
        need = (sb.len_code == LEN_1BYTE) ? 1 : (sb.len_code == LEN_2BYTE) ? 2 : 4;
        roll = $urandom_range(99);
        if (sb.len_code == LEN_INVALID || roll >= 92) begin
            repeat ($urandom_range(1, 6)) bytes = {bytes, 8'($urandom)};
        end else begin
            units = $urandom_range(1, 4);
            repeat (units) begin
                if ($urandom_range(99) == 0) begin
                    field = $urandom_range(64, 255);
                end else begin
                    field = $urandom_range(0, 6);
                end
                body = field;
                if (roll >= 80) begin
                    field = $urandom;
                    body  = $urandom_range(0, 6);
                end
                for (int i = need - 1; i >= 0; i--) begin
                    bytes = {bytes, field[8*i +: 8]};
                end
                repeat (body) bytes = {bytes, 8'($urandom)};
            end
            if (roll >= 80) begin
                keep = $urandom_range(1, bytes.size());
                while (bytes.size() > keep) begin
                    void'(bytes.pop_back());
                end
            end
        end
        send_buffer(bytes);
    endtask

    len_code_t phase_codes[4] = '{LEN_1BYTE, LEN_2BYTE, LEN_4BYTE, LEN_INVALID};

    initial begin
        int target;
        int start;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_buffer('{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF});
        write_len_code(LEN_1BYTE);
        send_buffer('{8'h00, 8'h02, 8'h00, 8'hFF, 8'h01, 8'hA5});
        send_buffer('{8'h03, 8'h11, 8'h22});
        write_len_code(LEN_2BYTE);
        send_buffer('{8'h00});
        send_buffer('{8'h00, 8'h01});
        write_len_code(LEN_INVALID);
        send_buffer('{8'h7E, 8'h81});
        write_len_code(LEN_4BYTE);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        write_len_code(LEN_1BYTE);
        send_beat(8'h01, 1'b0);
        send_beat(8'h3C, 1'b1);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 62 : 0;
            recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 18 : 0;
            foreach (phase_codes[p]) begin
                write_len_code(phase_codes[p]);
                target = (phase_codes[p] == LEN_INVALID) ? 5 : 20;
                start  = counted_beats;
                while (counted_beats - start < target) begin
                    if ($urandom_range(14) == 0) begin
                        wait_drained();
                    end
                    send_random_buffer();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS length_prefixed_to_annexb_unit");
        end else begin
            $display("FAIL length_prefixed_to_annexb_unit");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lp2ab_pkg.sv
rtl/lp2ab_front.sv
rtl/lp2ab_queue.sv
rtl/lp2ab_back.sv
rtl/length_prefixed_to_annexb_unit.sv
sim/length_prefixed_to_annexb_unit_test.sv
